FILE: rtl/css_pkg.sv
`timescale 1ns / 1ps

package css_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SWAP_W     = 11;
	localparam int MAX_SWAPS  = DEPTH * (DEPTH - 1) / 2;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] sorted_value;
		logic                         last_res;
		logic [SWAP_W-1:0]            swap_count;
		logic                         overflow;
	} result_t;

	// Pass direction: forward bubbles the maximum up, backward sinks the minimum.
	typedef enum logic {
		DIR_FWD = 1'b0,
		DIR_BWD = 1'b1
	} dir_t;

	// Outcome of one compare-exchange step.
	typedef struct packed {
		logic                         swap;
		logic signed [DATA_WIDTH-1:0] put;
		logic signed [DATA_WIDTH-1:0] keep;
	} step_t;

endpackage

FILE: rtl/css_store.sv
`timescale 1ns / 1ps

module css_store import css_pkg::*; (
	input  logic                         clk,
	input  logic                         we,
	input  logic [IDX_W-1:0]             waddr,
	input  logic signed [DATA_WIDTH-1:0] wdata,
	input  logic [IDX_W-1:0]             raddr,
	output logic signed [DATA_WIDTH-1:0] rdata
);

	logic signed [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/css_step.sv
`timescale 1ns / 1ps

module css_step import css_pkg::*; (
	input  dir_t                         dir,
	input  logic signed [DATA_WIDTH-1:0] carry,
	input  logic signed [DATA_WIDTH-1:0] peer,
	output step_t                        step
);

	logic greater;

	// Forward: carry sits left of peer. Backward: peer sits left of carry.
	always_comb begin
		case (dir)
			DIR_FWD: greater = carry > peer;
			DIR_BWD: greater = peer > carry;
			default: greater = 1'b0;
		endcase
		step.swap = greater;
		step.put  = greater ? peer : carry;
		step.keep = greater ? carry : peer;
	end

endmodule

FILE: rtl/cocktail_shaker_sorter_unit.sv
`timescale 1ns / 1ps
// Load: one beat per cycle while busy is low; the beat marked last starts the sort.
// Sort (n >= 2): one compare-exchange per cycle on a single comparator, a setup state
// (S_FIRST) before the first pass and a flush state (S_FLUSH) after each pass.
// Emit: one result beat per cycle on done, each in the cycle after its emit cycle;
// busy drops as the last beat leaves, and the receiver cannot stall them.
// Reset (arst_n low) clears all control state; the element store keeps no reset value.

module cocktail_shaker_sorter_unit import css_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	// One-hot sequencer.
	typedef enum logic [5:0] {
		S_LOAD   = 6'b000001,
		S_FIRST  = 6'b000010,
		S_CMP    = 6'b000100,
		S_FLUSH  = 6'b001000,
		S_EPRIME = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             count_q;
	logic [SWAP_W-1:0]            swap_q;
	logic                         ovf_q;
	logic [IDX_W-1:0]             lb_q;
	logic [IDX_W-1:0]             hb_q;
	logic                         swapped_q;
	dir_t                         dir_q;
	logic [IDX_W-1:0]             ptr_q;
	logic [IDX_W-1:0]             cnt_q;
	logic [IDX_W-1:0]             eidx_q;
	logic                         done_q;
	logic signed [DATA_WIDTH-1:0] carry_q;
	logic signed [DATA_WIDTH-1:0] last_wr_q;
	result_t                      result_q;

	logic                         load_fire;
	logic                         full;
	logic [CNT_W-1:0]             n_next;
	logic [IDX_W-1:0]             hb_dec;
	logic [IDX_W-1:0]             lb_inc;
	logic                         pass_done;
	logic                         is_last;

	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	logic signed [DATA_WIDTH-1:0] mem_wdata;
	logic [IDX_W-1:0]             mem_raddr;
	logic signed [DATA_WIDTH-1:0] mem_rdata;
	step_t                        step;

	assign busy      = (state_q != S_LOAD);
	assign load_fire = start && !busy;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign n_next    = full ? count_q : count_q + CNT_W'(1);
	assign hb_dec    = hb_q - IDX_W'(1);
	assign lb_inc    = lb_q + IDX_W'(1);
	assign is_last   = (CNT_W'(eidx_q) + CNT_W'(1)) == count_q;

	// Stop after a clean pass, or when the next pass would have no pairs left.
	always_comb begin
		case (dir_q)
			DIR_FWD: pass_done = !swapped_q || (hb_dec == lb_q);
			DIR_BWD: pass_done = !swapped_q || (hb_q == lb_inc);
			default: pass_done = 1'b1;
		endcase
	end

	// Element store: one write and one registered read per cycle.
	css_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Shared comparator: the running carry against the freshly read neighbor.
	css_step u_step (
		.dir   (dir_q),
		.carry (carry_q),
		.peer  (mem_rdata),
		.step  (step)
	);

	// Memory port steering. During a pass the read runs two slots ahead of the
	// write, so a read never lands on the entry being written.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = step.put;
		mem_raddr = '0;
		case (state_q)
			S_LOAD: begin
				mem_we    = load_fire && !full;
				mem_waddr = count_q[IDX_W-1:0];
				mem_wdata = item.value;
			end
			S_FIRST: begin
				mem_raddr = IDX_W'(1);
			end
			S_CMP: begin
				mem_we    = 1'b1;
				mem_raddr = (dir_q == DIR_FWD) ? ptr_q + IDX_W'(2) : ptr_q - IDX_W'(2);
			end
			S_FLUSH: begin
				// Park the carry at the end of the window; prefetch the next pass.
				mem_we    = 1'b1;
				mem_wdata = carry_q;
				mem_raddr = (dir_q == DIR_FWD) ? hb_dec - IDX_W'(1) : lb_inc + IDX_W'(1);
			end
			S_EPRIME: begin
				mem_raddr = '0;
			end
			S_EMIT: begin
				mem_raddr = eidx_q + IDX_W'(1);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			count_q   <= '0;
			swap_q    <= '0;
			ovf_q     <= 1'b0;
			lb_q      <= '0;
			hb_q      <= '0;
			swapped_q <= 1'b0;
			dir_q     <= DIR_FWD;
			ptr_q     <= '0;
			cnt_q     <= '0;
			eidx_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_EMIT);
			case (state_q)
				S_LOAD: begin
					if (load_fire) begin
						// Store while there is room; otherwise drop the beat and flag it.
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							state_q <= (n_next >= CNT_W'(2)) ? S_FIRST : S_EPRIME;
						end
					end
				end
				S_FIRST: begin
					// Entry 0 is now in the read register; open the full window.
					lb_q      <= '0;
					hb_q      <= IDX_W'(count_q - CNT_W'(1));
					cnt_q     <= IDX_W'(count_q - CNT_W'(1));
					ptr_q     <= '0;
					dir_q     <= DIR_FWD;
					swapped_q <= 1'b0;
					state_q   <= S_CMP;
				end
				S_CMP: begin
					if (step.swap) begin
						swap_q    <= swap_q + SWAP_W'(1);
						swapped_q <= 1'b1;
					end
					ptr_q <= (dir_q == DIR_FWD) ? ptr_q + IDX_W'(1) : ptr_q - IDX_W'(1);
					cnt_q <= cnt_q - IDX_W'(1);
					if (cnt_q == IDX_W'(1)) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (pass_done) begin
						state_q <= S_EPRIME;
					end else begin
						swapped_q <= 1'b0;
						state_q   <= S_CMP;
						if (dir_q == DIR_FWD) begin
							// Shrink the top of the window and turn downward.
							hb_q  <= hb_dec;
							dir_q <= DIR_BWD;
							ptr_q <= hb_dec;
							cnt_q <= hb_dec - lb_q;
						end else begin
							// Shrink the bottom of the window and turn upward.
							lb_q  <= lb_inc;
							dir_q <= DIR_FWD;
							ptr_q <= lb_inc;
							cnt_q <= hb_q - lb_inc;
						end
					end
				end
				S_EPRIME: begin
					eidx_q  <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					eidx_q <= eidx_q + IDX_W'(1);
					if (is_last) begin
						// Run complete: drop the run's totals and reopen for loading.
						count_q <= '0;
						swap_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_FIRST: begin
				carry_q <= mem_rdata;
			end
			S_CMP: begin
				carry_q   <= step.keep;
				last_wr_q <= step.put;
			end
			S_FLUSH: begin
				// The last value written sits at the start of the next pass.
				carry_q <= last_wr_q;
			end
			default: begin
				carry_q <= carry_q;
			end
		endcase
		if (state_q == S_EMIT) begin
			result_q.sorted_value <= mem_rdata;
			result_q.last_res     <= is_last;
			result_q.swap_count   <= swap_q;
			result_q.overflow     <= ovf_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTH
	a_done_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_EMIT))
		else $error("result beat without an emit cycle");

	a_cmp_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (cnt_q != '0) && (lb_q < hb_q))
		else $error("compare step with an empty window");

	a_swap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		swap_q <= SWAP_W'(MAX_SWAPS))
		else $error("swap count above the inversion limit");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count beyond store depth");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && is_last |=> (count_q == '0) && (swap_q == '0) && !ovf_q)
		else $error("run totals not cleared after last result");
`endif

endmodule

FILE: tb/sv/css_result_checker.sv
`timescale 1ns / 1ps

module css_result_checker import css_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        done,
	input  result_t     result,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned results_seen,
	output int unsigned peak_swaps
);

	logic signed [DATA_WIDTH-1:0] gathered [DEPTH];
	int unsigned                  gathered_n = 0;
	logic                         dropped    = 1'b0;
	result_t                      sorted_q [$];

	initial begin
		mismatches   = 0;
		pending      = 0;
		results_seen = 0;
		peak_swaps   = 0;
	end

	// Shaker-sort the gathered elements, count swaps, queue one result per element.
	function automatic void queue_sorted_run();
		logic signed [DATA_WIDTH-1:0] vals [DEPTH];
		logic signed [DATA_WIDTH-1:0] tmp;
		logic [SWAP_W-1:0]            swaps;
		logic                         moved;
		int                           lo, hi, i;
		result_t                      r;
		vals  = gathered;
		swaps = '0;
		lo    = 0;
		hi    = gathered_n - 1;
		moved = (gathered_n > 1);
		while (moved) begin
			moved = 1'b0;
			for (i = lo; i < hi; i++) begin
				if (vals[i] > vals[i+1]) begin
					tmp       = vals[i];
					vals[i]   = vals[i+1];
					vals[i+1] = tmp;
					moved     = 1'b1;
					swaps++;
				end
			end
			if (!moved)
				break;
			moved = 1'b0;
			hi--;
			for (i = hi; i > lo; i--) begin
				if (vals[i-1] > vals[i]) begin
					tmp       = vals[i-1];
					vals[i-1] = vals[i];
					vals[i]   = tmp;
					moved     = 1'b1;
					swaps++;
				end
			end
			lo++;
		end
		if (swaps > peak_swaps)
			peak_swaps = swaps;
		for (i = 0; i < gathered_n; i++) begin
			r.sorted_value = vals[i];
			r.last_res     = (i == gathered_n - 1);
			r.swap_count   = swaps;
			r.overflow     = dropped;
			sorted_q.push_back(r);
		end
	endfunction

	function automatic int field_differs(string field, logic [63:0] want, logic [63:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			gathered_n = 0;
			dropped    = 1'b0;
			sorted_q.delete();
			pending   <= 0;
		end else begin
			if (done) begin
				results_seen++;
				if (sorted_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, actual value %0d last %0b",
						$time, result.sorted_value, result.last_res);
				end else begin
					want = sorted_q.pop_front();
					mismatches += field_differs("sorted_value",
						$unsigned(want.sorted_value), $unsigned(result.sorted_value));
					mismatches += field_differs("last_res", want.last_res, result.last_res);
					mismatches += field_differs("swap_count", want.swap_count, result.swap_count);
					mismatches += field_differs("overflow", want.overflow, result.overflow);
				end
			end
			if (start && !busy) begin
				if (gathered_n < DEPTH) begin
					gathered[gathered_n] = item.value;
					gathered_n++;
				end else begin
					dropped = 1'b1;
				end
				if (item.last) begin
					queue_sorted_run();
					gathered_n = 0;
					dropped    = 1'b0;
				end
			end
			pending <= sorted_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_cocktail_shaker_sorter_unit.sv
`timescale 1ns / 1ps

module tb_cocktail_shaker_sorter_unit;
	import css_pkg::*;

	localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam int ITEM_TARGET = 410;

	// Value flavors for a run's random content.
	typedef enum int {
		VALS_WIDE,
		VALS_CLUSTERED,
		VALS_EXTREME,
		VALS_MIXED
	} val_mix_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	int unsigned mismatches, pending, results_seen, peak_swaps;
	int unsigned beats_sent    = 0;
	int unsigned runs_sent     = 0;
	int unsigned overflow_runs = 0;

	always #4 clk = ~clk;

	cocktail_shaker_sorter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	css_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.done         (done),
		.result       (result),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.peak_swaps   (peak_swaps)
	);

	// Sender idle time: mostly back-to-back, some short gaps, a few long ones.
	// Drop start only when a gap is taken, so a held start never toggles within a step.
	task automatic idle_gap();
		int pick;
		int gap;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(4, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Offer one beat and hold it until the edge where busy is low accepts it.
	task automatic send_beat(input logic signed [DATA_WIDTH-1:0] v, input logic is_last);
		start <= 1'b1;
		item  <= '{value: v, last: is_last};
		do
			@(posedge clk);
		while (busy);
		beats_sent++;
		idle_gap();
	endtask

	// Hold the sender until every queued result has left the block.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_WIDTH-1:0] pick_value(input val_mix_t mix);
		logic signed [DATA_WIDTH-1:0] corner [5];
		corner = '{VAL_MIN, VAL_MAX, 0, -1, 1};
		case (mix)
			VALS_WIDE:      return $urandom;
			// narrow window around zero: plenty of ties and sign changes
			VALS_CLUSTERED: return $signed($urandom_range(0, 8)) - 4;
			VALS_EXTREME:   return corner[$urandom_range(0, 4)];
			default: begin
				if ($urandom_range(0, 3) == 0)
					return corner[$urandom_range(0, 4)];
				return $urandom;
			end
		endcase
	endfunction

	// One complete run of n beats; the final beat carries last. Beyond DEPTH the
	// block drops beats, including the last one, which still kicks off the sort.
	task automatic send_run(input int n, input val_mix_t mix);
		for (int k = 0; k < n; k++)
			send_beat(pick_value(mix), k == n - 1);
		runs_sent++;
		if (n > DEPTH)
			overflow_runs++;
	endtask

	task automatic send_list(input logic signed [DATA_WIDTH-1:0] vals [$]);
		foreach (vals[k])
			send_beat(vals[k], k == vals.size() - 1);
		runs_sent++;
	endtask

	initial begin
		int pick;
		int len;
		// hold reset low, then release on an edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single element, two extremes, already sorted, fully reversed,
		// ties, and mixed signs.
		send_list('{VAL_MIN});
		send_list('{VAL_MAX, VAL_MIN});
		send_list('{-1, 0, 1});
		send_list('{VAL_MAX, 1, 0, -1, VAL_MIN});
		send_list('{5, 5, -5, 5});
		send_list('{1, VAL_MIN, VAL_MAX, -2, 0, 32'sh4000_0000});

		// pause the sender until the block has emptied its result stream
		drain_results();

		// Full store, strictly descending: every pair is an inversion.
		for (int k = 0; k < DEPTH; k++)
			send_beat((31 - k) * 32'sh0300_0001, k == DEPTH - 1);
		runs_sent++;
		// Past the depth: extra beats and the last one are dropped, overflow set.
		send_run(DEPTH + 3, VALS_MIXED);

		// Random runs, mostly short so many sorts complete; now and then a long
		// or overflowing one.
		while (beats_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = $urandom_range(1, 8);
			else if (pick < 88)
				len = $urandom_range(9, 24);
			else if (pick < 95)
				len = $urandom_range(25, DEPTH - 1);
			else
				len = $urandom_range(DEPTH, DEPTH + 6);
			send_run(len, val_mix_t'($urandom_range(0, 3)));
			if ($urandom_range(0, 19) == 0)
				drain_results();
		end

		// wait out outstanding results, then watch a while for strays
		drain_results();
		repeat (300) @(posedge clk);

		$display("Covered %0d runs from %0d beats (%0d past the store depth); %0d results checked,",
			runs_sent, beats_sent, overflow_runs, results_seen);
		$display("largest swap count predicted %0d.", peak_swaps);
		if (mismatches == 0 && pending == 0)
			$display("cocktail_shaker_sorter_unit verification clean");
		else
			$display("cocktail_shaker_sorter_unit verification failed");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("cocktail_shaker_sorter_unit verification failed");
		$finish;
	end

endmodule

FILE: cocktail_shaker_sorter_unit.f
rtl/css_pkg.sv
rtl/css_store.sv
rtl/css_step.sv
rtl/cocktail_shaker_sorter_unit.sv
tb/sv/css_result_checker.sv
tb/sv/tb_cocktail_shaker_sorter_unit.sv
